### hdl/key_press_classifier_with_queue_defines.svh
// Assertion macros for the key press classifier.
// The macros expect clk and arst_n in the scope where they are used.
`ifndef KEY_PRESS_CLASSIFIER_WITH_QUEUE_DEFINES_SVH
`define KEY_PRESS_CLASSIFIER_WITH_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define KPC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// Check that a condition never holds outside reset.
`define KPC_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);
`else
`define KPC_ASSERT(name, prop, msg)
`define KPC_NEVER(name, expr, msg)
`endif
`endif

### hdl/kpc_pkg.sv
package kpc_pkg;

	localparam int MODE_W    = 2;
	localparam int CODE_W    = 2;
	localparam int TICK_W    = 16;
	localparam int CFG_IDX_W = 2;

	// input modes
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

	// operations passed from front to back
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_EDGE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	// key codes
	localparam logic [CODE_W-1:0] KEY_NONE  = 2'd0;
	localparam logic [CODE_W-1:0] KEY_SHORT = 2'd1;
	localparam logic [CODE_W-1:0] KEY_LONG  = 2'd2;
	localparam logic [CODE_W-1:0] KEY_DUAL  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd2;

	// configuration reset values
	localparam logic [TICK_W-1:0] SETTLE_RESET = 16'd8;
	localparam logic [TICK_W-1:0] LONG_RESET   = 16'd200;
	localparam logic [TICK_W-1:0] HOLD_RESET   = 16'd35;

	typedef struct packed {
		logic [1:0] kind;
		logic       pin;
	} kpc_op_t;

endpackage

### hdl/kpc_ifs.sv
interface kpc_event_if import kpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic              pin_level;

	modport source (output valid, output mode, output pin_level, input ready);
	modport sink (input valid, input mode, input pin_level, output ready);
endinterface

interface kpc_code_if import kpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] key_code;

	modport source (output valid, output key_code, input ready);
	modport sink (input valid, input key_code, output ready);
endinterface

interface kpc_cfg_if import kpc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [TICK_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/kpc_front.sv
module kpc_front import kpc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	kpc_event_if.sink     evt,
	output logic          op_valid,
	output kpc_op_t       op,
	input  logic          op_ready
);

	logic    valid_s1;
	kpc_op_t op_s1;
	kpc_op_t op_dec;
	logic    accept;
	logic    push;

	always_comb begin
		op_dec.pin = evt.pin_level;
		unique case (evt.mode)
			MODE_TICK: op_dec.kind = OP_TICK;
			MODE_EDGE: op_dec.kind = OP_EDGE;
			MODE_READ: op_dec.kind = OP_READ;
			default:   op_dec.kind = OP_NOP;
		endcase
	end

	assign push      = valid_s1 && op_ready;
	assign evt.ready = !valid_s1 || op_ready;
	assign accept    = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_dec;
		end
	end

	assign op_valid = valid_s1;
	assign op       = op_s1;

endmodule

### hdl/kpc_queue.sv
module kpc_queue import kpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  kpc_op_t in_op,
	output logic    in_ready,
	output logic    out_valid,
	output kpc_op_t out_op,
	input  logic    out_pop
);

	localparam int QD = 2;

	kpc_op_t    slot_q [QD];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign in_ready  = cnt_q != 2'(QD);
	assign out_valid = cnt_q != 2'd0;
	assign out_op    = slot_q[rd_q];
	assign do_push   = in_valid && in_ready;
	assign do_pop    = out_pop && out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= in_op;
		end
	end

endmodule

### hdl/kpc_back.sv
`include "key_press_classifier_with_queue_defines.svh"

module kpc_back import kpc_pkg::*; #(
	parameter int RING_DEPTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	input  kpc_op_t   op,
	output logic      op_pop,
	kpc_cfg_if.sink   cfg,
	kpc_code_if.source code
);

	localparam int CW = $clog2(RING_DEPTH);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);
	localparam logic [CW-1:0] CNT_TWO  = CW'(2);
	localparam logic [CW-1:0] CNT_LAST = CW'(RING_DEPTH - 1);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WAIT = 2'd1;
	localparam logic [1:0] PH_HELD = 2'd2;

	logic [TICK_W-1:0] settle_q;
	logic [TICK_W-1:0] long_q;
	logic [TICK_W-1:0] hold_ticks_q;

	logic [TICK_W-1:0] cd_q, cd_d;
	logic [1:0]        ph_q, ph_d;
	logic [TICK_W-1:0] hold_q, hold_d;
	logic [CW-1:0]     count_q;
	logic [CODE_W-1:0] ring_q [RING_DEPTH];
	logic [CODE_W-1:0] shift1 [RING_DEPTH];
	logic [CODE_W-1:0] shift2 [RING_DEPTH];

	logic              out_valid_q;
	logic [CODE_W-1:0] key_code_q;

	logic              fire;
	logic              push;
	logic [CODE_W-1:0] push_code;
	logic              pop_one;
	logic              pop_two;
	logic [CODE_W-1:0] result;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q     <= SETTLE_RESET;
			long_q       <= LONG_RESET;
			hold_ticks_q <= HOLD_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SETTLE: settle_q     <= cfg.data;
				REG_LONG:   long_q       <= cfg.data;
				REG_HOLD:   hold_ticks_q <= cfg.data;
				default:    ;
			endcase
		end
	end

	// take one op whenever the output register is free or being drained
	assign fire   = op_valid && (!out_valid_q || code.ready);
	assign op_pop = fire;

	always_comb begin
		cd_d      = cd_q;
		ph_d      = ph_q;
		hold_d    = hold_q;
		push      = 1'b0;
		push_code = KEY_SHORT;
		pop_one   = 1'b0;
		pop_two   = 1'b0;
		result    = KEY_NONE;
		if (fire) begin
			unique case (op.kind)
				OP_TICK: begin
					if (hold_q != '0) begin
						hold_d = hold_q - TICK_W'(1);
					end
					if (cd_q != '0) begin
						cd_d = cd_q - TICK_W'(1);
						if (cd_q == TICK_W'(1)) begin
							unique case (ph_q)
								PH_IDLE: begin
									ph_d = PH_WAIT;
									cd_d = long_q;
								end
								PH_WAIT: begin
									push   = 1'b1;
									hold_d = hold_ticks_q;
									if (op.pin) begin
										push_code = KEY_SHORT;
										ph_d      = PH_IDLE;
									end else begin
										push_code = KEY_LONG;
										ph_d      = PH_HELD;
									end
								end
								PH_HELD: ph_d = PH_IDLE;
								default: ;
							endcase
						end
					end
				end
				OP_EDGE: cd_d = settle_q;
				OP_READ: begin
					if (count_q != '0 && hold_q == '0) begin
						if (count_q != CNT_ONE && ring_q[0] == KEY_SHORT &&
								ring_q[1] == KEY_SHORT) begin
							pop_two = 1'b1;
							result  = KEY_DUAL;
						end else begin
							pop_one = 1'b1;
							result  = ring_q[0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q        <= '0;
			ph_q        <= PH_IDLE;
			hold_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cd_q   <= cd_d;
			ph_q   <= ph_d;
			hold_q <= hold_d;
			// a push that fills the ring wraps the count and drops its contents
			if (push) begin
				count_q <= (count_q == CNT_LAST) ? '0 : count_q + CNT_ONE;
			end else if (pop_one) begin
				count_q <= count_q - CNT_ONE;
			end else if (pop_two) begin
				count_q <= count_q - CNT_TWO;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (code.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			key_code_q <= result;
		end
	end

	// code queue: head at entry 0, write at the fill count
	for (genvar g = 0; g < RING_DEPTH; g++) begin : g_ring
		if (g + 1 < RING_DEPTH) begin : g_s1
			assign shift1[g] = ring_q[g+1];
		end else begin : g_h1
			assign shift1[g] = ring_q[g];
		end
		if (g + 2 < RING_DEPTH) begin : g_s2
			assign shift2[g] = ring_q[g+2];
		end else begin : g_h2
			assign shift2[g] = ring_q[g];
		end

		always_ff @(posedge clk) begin
			if (push && count_q == CW'(g)) begin
				ring_q[g] <= push_code;
			end else if (pop_one) begin
				ring_q[g] <= shift1[g];
			end else if (pop_two) begin
				ring_q[g] <= shift2[g];
			end
		end
	end

	assign code.valid    = out_valid_q;
	assign code.key_code = key_code_q;

	`KPC_ASSERT(a_dual_pops_two, pop_two |=> count_q == $past(count_q) - CNT_TWO, "pair not taken")
	`KPC_ASSERT(a_push_loads_hold, push |=> hold_q == $past(hold_ticks_q), "hold-off not restarted")
	`KPC_NEVER(a_read_in_hold, fire && result != KEY_NONE && hold_q != '0, "code read in hold-off")
	`KPC_ASSERT(a_result_from_op, $rose(out_valid_q) |-> $past(fire), "result without an op")

endmodule

### hdl/key_press_classifier_with_queue.sv
// Key press classifier with code queue. Each beat on evt is one event from a
// push button: a tick carrying the sampled pin level (low means held down),
// an edge event, or a read request; mode 3 does nothing. Every event beat
// produces exactly one beat on code, in order: key_code is NONE for ticks and
// edges, and on a read the oldest queued code (SHORT, LONG, or DUAL when two
// SHORT codes sit at the head), or NONE while the queue is empty or the
// readout hold-off still runs. An edge restarts the settle countdown; when it
// expires in the idle phase the classifier arms the long-press wait, and when
// that expires the pin level decides between LONG and SHORT. The queue holds
// RING_DEPTH - 1 codes; the push that would fill it empties it and loses them.
// Throughput is one event per clock while code is ready: the front register,
// the two-entry op queue and the executor each move one beat a cycle; an
// event is registered in front and queue, its result in the output register.
// The queue between front and executor lets the input keep flowing while
// code is stalled, until its two entries fill. Configuration writes on cfg
// are always accepted and belong to idle periods; register 0 is the settle
// time, 1 the long-press wait, 2 the hold-off, all in ticks; others ignored.
module key_press_classifier_with_queue import kpc_pkg::*; #(
	parameter int RING_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	kpc_event_if.sink   evt,
	kpc_code_if.source  code,
	kpc_cfg_if.sink     cfg
);

	// front to queue
	logic    fq_valid;
	kpc_op_t fq_op;
	logic    fq_ready;

	// queue to back
	logic    qb_valid;
	kpc_op_t qb_op;
	logic    qb_pop;

	// accept and decode: register the decoded event
	kpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.op_valid (fq_valid),
		.op       (fq_op),
		.op_ready (fq_ready)
	);

	// decouple: hold ops while the back stalls on code
	kpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_op     (fq_op),
		.in_ready  (fq_ready),
		.out_valid (qb_valid),
		.out_op    (qb_op),
		.out_pop   (qb_pop)
	);

	// execute: countdowns, phase machine, code queue, output register
	kpc_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (qb_valid),
		.op       (qb_op),
		.op_pop   (qb_pop),
		.cfg      (cfg),
		.code     (code)
	);

endmodule
